>>> hdl/tmvs_pkg.sv
// Shared types, constants and helper functions of the typed memory value scanner.
package tmvs_pkg;

    localparam int WORD_BYTES      = 8;
    localparam int MAX_VALUE_BYTES = 8;
    localparam int VALUE_BYTES     = 8;
    localparam int LANES           = 2 * WORD_BYTES;
    localparam int LANE_W          = $clog2(LANES);
    localparam int BUF_BYTES       = LANES + VALUE_BYTES;

    typedef enum logic [2:0] {
        REG_VALUE_TYPE      = 3'd0,
        REG_VALUE_SIZE      = 3'd1,
        REG_LOW_VALUE       = 3'd2,
        REG_HIGH_VALUE      = 3'd3,
        REG_MATCH_ALIGNMENT = 3'd4,
        REG_BYTE_BUDGET     = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        TYPE_INT8   = 4'd0,
        TYPE_UINT8  = 4'd1,
        TYPE_INT16  = 4'd2,
        TYPE_UINT16 = 4'd3,
        TYPE_INT32  = 4'd4,
        TYPE_UINT32 = 4'd5,
        TYPE_INT64  = 4'd6,
        TYPE_UINT64 = 4'd7,
        TYPE_FLOAT  = 4'd8,
        TYPE_DOUBLE = 4'd9,
        TYPE_STRING = 4'd10
    } vtype_t;

    // Per-item settings that every lane sees
    typedef struct packed {
        logic        held_valid;
        logic        contig;
        logic        region_end;
        logic [3:0]  size;
        logic [2:0]  align_mask;
        vtype_t      vtype;
        logic        eq_mode;
        logic        range_ok;
        logic [63:0] lo_cut;
        logic [63:0] lo_key;
        logic [63:0] hi_key;
    } lane_ctl_t;

    // One scanned item waiting for the merge stage
    typedef struct packed {
        logic [LANES-1:0]       fit;
        logic [LANES-1:0]       hit;
        logic [8*BUF_BYTES-1:0] bytes;
        logic [63:0]            held_address;
        logic [63:0]            word_address;
    } item_t;

    // Keep the low size bytes of a value
    function automatic logic [63:0] size_mask(input logic [3:0] size);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < VALUE_BYTES; b++) begin
            if (4'(b) < size) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Map a value onto an unsigned ordering key; top bit flags an unordered value
    function automatic logic [64:0] order_key(input logic [63:0] x, input vtype_t t);
        logic [63:0] key;
        logic        bad;
        key = '0;
        bad = 1'b0;
        case (t)
            TYPE_INT8:   key = {56'd0, ~x[7], x[6:0]};
            TYPE_UINT8:  key = {56'd0, x[7:0]};
            TYPE_INT16:  key = {48'd0, ~x[15], x[14:0]};
            TYPE_UINT16: key = {48'd0, x[15:0]};
            TYPE_INT32:  key = {32'd0, ~x[31], x[30:0]};
            TYPE_UINT32: key = {32'd0, x[31:0]};
            TYPE_INT64:  key = {~x[63], x[62:0]};
            TYPE_UINT64: key = x;
            TYPE_FLOAT:
            begin
                bad = (&x[30:23]) && (|x[22:0]);
                if (x[30:0] == 31'd0) begin
                    key = {32'd0, 32'h8000_0000};
                end else if (x[31]) begin
                    key = {32'd0, ~x[31:0]};
                end else begin
                    key = {32'd0, 1'b1, x[30:0]};
                end
            end
            TYPE_DOUBLE:
            begin
                bad = (&x[62:52]) && (|x[51:0]);
                if (x[62:0] == 63'd0) begin
                    key = 64'h8000_0000_0000_0000;
                end else if (x[63]) begin
                    key = ~x;
                end else begin
                    key = {1'b1, x[62:0]};
                end
            end
            default: bad = 1'b1;
        endcase
        return {bad, key};
    endfunction

endpackage

>>> hdl/tmvs_in_if.sv
// Request channel carrying one memory word per transfer.
interface tmvs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] mem_word;
    logic [63:0] word_address;
    logic        region_end;

    modport source (output valid, output mem_word, output word_address, output region_end,
                    input ready);
    modport sink (input valid, input mem_word, input word_address, input region_end,
                  output ready);
endinterface

>>> hdl/tmvs_out_if.sv
// Result channel carrying one match or limit notice per transfer.
interface tmvs_out_if;
    logic        valid;
    logic        ready;
    logic        is_match;
    logic [63:0] match_address;
    logic [63:0] match_value;
    logic [31:0] match_total;
    logic        limit_reached;
    logic        last_of_item;

    modport source (output valid, output is_match, output match_address, output match_value,
                    output match_total, output limit_reached, output last_of_item,
                    input ready);
    modport sink (input valid, input is_match, input match_address, input match_value,
                  input match_total, input limit_reached, input last_of_item,
                  output ready);
endinterface

>>> hdl/tmvs_lane.sv
// One window comparator: fit check and equal or range test at a fixed byte offset.
module tmvs_lane #(
    parameter int LANE = 0
) (
    input  tmvs_pkg::lane_ctl_t                  ctl,
    input  logic [8*tmvs_pkg::BUF_BYTES-1:0]     bytes,
    output logic                                 fit,
    output logic                                 hit
);

    logic [63:0] win;
    logic [64:0] win_key;
    logic [5:0]  win_end;
    logic        start_ok;
    logic        room;
    logic        aligned;
    logic        match_raw;

    // Cut the window and test where it ends
    always_comb
    begin
        win      = bytes[8*LANE +: 64] & tmvs_pkg::size_mask(ctl.size);
        win_end  = 6'(LANE) + {2'b00, ctl.size};
        start_ok = (LANE < tmvs_pkg::WORD_BYTES) ? ctl.held_valid : ctl.region_end;
        if ((LANE < tmvs_pkg::WORD_BYTES) && !ctl.contig) begin
            room = win_end <= 6'(tmvs_pkg::WORD_BYTES);
        end else begin
            room = win_end <= 6'(tmvs_pkg::LANES);
        end
        aligned = (3'(LANE % tmvs_pkg::WORD_BYTES) & ctl.align_mask) == 3'd0;
        fit     = start_ok && room && aligned;
    end

    // Compare exactly or by ordering key
    always_comb
    begin
        win_key = tmvs_pkg::order_key(win, ctl.vtype);
        if (ctl.eq_mode) begin
            match_raw = win == ctl.lo_cut;
        end else begin
            match_raw = ctl.range_ok && !win_key[64] &&
                        (win_key[63:0] >= ctl.lo_key) && (win_key[63:0] <= ctl.hi_key);
        end
        hit = fit && match_raw;
    end

endmodule

>>> hdl/tmvs_merge.sv
// Merge stage: walks the lane results in order, applies the byte budget, emits results.
module tmvs_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  tmvs_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_done,
    input  logic [3:0]          size,
    input  logic [31:0]         budget,
    tmvs_out_if.source          out_res
);

    localparam int LANES  = tmvs_pkg::LANES;
    localparam int LANE_W = tmvs_pkg::LANE_W;

    logic [LANES-1:0] done_mask_reg;
    logic [31:0]      bytes_stored_reg;
    logic [31:0]      found_count_reg;
    logic             limit_hit_reg;
    logic             out_valid_reg;
    logic             is_match_reg;
    logic [63:0]      match_address_reg;
    logic [63:0]      match_value_reg;
    logic [31:0]      match_total_reg;
    logic             limit_reached_reg;
    logic             last_of_item_reg;

    logic [LANES-1:0] pending;
    logic [LANES-1:0] sel_vec;
    logic [LANES-1:0] above;
    logic [LANES-1:0] rest;
    logic [LANE_W-1:0] lane;
    logic             have;
    logic [32:0]      sum1;
    logic [32:0]      sum2;
    logic             over;
    logic             over2;
    logic             more;
    logic             out_free;
    logic             emit;
    logic             finish;
    logic [63:0]      base;
    logic [63:0]      sel_address;
    logic [63:0]      sel_value;
    logic [8*tmvs_pkg::BUF_BYTES-1:0] shifted;

    // Pick the next window and look ahead for the item's last result
    always_comb
    begin
        pending = ~done_mask_reg;
        sum1    = {1'b0, bytes_stored_reg} + {29'd0, size};
        sum2    = sum1 + {29'd0, size};
        over    = sum1 > {1'b0, budget};
        over2   = sum2 > {1'b0, budget};
        sel_vec = over ? (item.fit & pending) : (item.hit & pending);
        lane    = '0;
        have    = 1'b0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                lane = LANE_W'(i);
                have = 1'b1;
            end
        end
        for (int i = 0; i < LANES; i++) begin
            above[i] = LANE_W'(i) > lane;
        end
        rest     = pending & above;
        more     = over2 ? |(item.fit & rest) : |(item.hit & rest);
        finish   = over || !more;
        out_free = !out_valid_reg || out_res.ready;
        emit     = item_valid && !limit_hit_reg && have && out_free;
        item_done = item_valid && (limit_hit_reg || !have || (out_free && finish));
    end

    // Form the address and value of the picked window
    always_comb
    begin
        base        = lane[LANE_W-1] ? item.word_address : item.held_address;
        sel_address = base + 64'(lane[LANE_W-2:0]);
        shifted     = item.bytes >> {lane, 3'b000};
        sel_value   = shifted[63:0] & tmvs_pkg::size_mask(size);
    end

    // Hold budget state and the output request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_mask_reg    <= '0;
            bytes_stored_reg <= '0;
            found_count_reg  <= '0;
            limit_hit_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (item_done) begin
                done_mask_reg <= '0;
            end else if (emit) begin
                done_mask_reg <= done_mask_reg | ~above;
            end
            if (emit) begin
                out_valid_reg     <= 1'b1;
                match_address_reg <= sel_address;
                last_of_item_reg  <= finish;
                if (over) begin
                    limit_hit_reg     <= 1'b1;
                    is_match_reg      <= 1'b0;
                    match_value_reg   <= '0;
                    match_total_reg   <= found_count_reg;
                    limit_reached_reg <= 1'b1;
                end else begin
                    bytes_stored_reg  <= sum1[31:0];
                    is_match_reg      <= 1'b1;
                    match_value_reg   <= sel_value;
                    limit_reached_reg <= 1'b0;
                    if (found_count_reg != 32'hFFFF_FFFF) begin
                        found_count_reg <= found_count_reg + 32'd1;
                        match_total_reg <= found_count_reg + 32'd1;
                    end else begin
                        match_total_reg <= found_count_reg;
                    end
                end
            end else if (out_res.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_res.valid         = out_valid_reg;
    assign out_res.is_match      = is_match_reg;
    assign out_res.match_address = match_address_reg;
    assign out_res.match_value   = match_value_reg;
    assign out_res.match_total   = match_total_reg;
    assign out_res.limit_reached = limit_reached_reg;
    assign out_res.last_of_item  = last_of_item_reg;

endmodule

>>> hdl/typed_memory_value_scanner_core.sv
// Top level of the typed memory value scanner: config, word history, lanes and merge.
//
// Usage: memory arrives on in_req as 8-byte words with their address and a
// region_end mark. The previous word is held so that windows cross word
// boundaries; sixteen lane comparators test every window start of the held and
// new word at once. Matches and the one-time budget notice leave on out_res,
// one per transfer, in address order, with last_of_item on the final result of
// the request that caused them. A request with no result produces nothing.
// A request's results pass the lane result register and then the output
// register before they turn valid on out_res. Throughput: one request per
// cycle while each yields at most one result and out_res does not stall; a
// request with several results holds the merge stage until all have left,
// since the output register takes one result a cycle when out_res is ready.
// When out_res stalls, the output register holds and the merge stage, then
// in_req.ready, back up behind it. Configuration must be written through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; the block
// itself does not enforce this. Reset clears the held word, the byte count,
// the match count and the limit flag, and loads the register defaults.
module typed_memory_value_scanner_core (
    input  logic        clk,
    input  logic        rst_n,
    tmvs_in_if.sink     in_req,
    tmvs_out_if.source  out_res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int LANES = tmvs_pkg::LANES;

    tmvs_pkg::vtype_t    value_type_reg;
    logic [3:0]          value_size_reg;
    logic [63:0]         low_value_reg;
    logic [63:0]         high_value_reg;
    logic [3:0]          match_alignment_reg;
    logic [31:0]         byte_budget_reg;

    logic [63:0]         held_word_reg;
    logic [63:0]         held_address_reg;
    logic                held_valid_reg;

    logic                s1_valid_reg;
    tmvs_pkg::item_t     s1_item_reg;
    tmvs_pkg::item_t     s1_item_next;

    tmvs_pkg::lane_ctl_t ctl;
    logic [3:0]          eff_size;
    logic [63:0]         size_bits;
    logic [63:0]         hi_cut;
    logic [64:0]         lo_k;
    logic [64:0]         hi_k;
    logic [LANES-1:0]    lane_fit;
    logic [LANES-1:0]    lane_hit;
    logic                in_acc;
    logic                item_done;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            value_type_reg      <= tmvs_pkg::TYPE_INT32;
            value_size_reg      <= 4'd4;
            low_value_reg       <= '0;
            high_value_reg      <= '0;
            match_alignment_reg <= 4'd1;
            byte_budget_reg     <= 32'd1048576;
        end else if (cfg_we) begin
            case (tmvs_pkg::reg_index_t'(cfg_index))
                tmvs_pkg::REG_VALUE_TYPE:      value_type_reg <= tmvs_pkg::vtype_t'(cfg_wdata[3:0]);
                tmvs_pkg::REG_VALUE_SIZE:      value_size_reg <= cfg_wdata[3:0];
                tmvs_pkg::REG_LOW_VALUE:       low_value_reg <= cfg_wdata;
                tmvs_pkg::REG_HIGH_VALUE:      high_value_reg <= cfg_wdata;
                tmvs_pkg::REG_MATCH_ALIGNMENT: match_alignment_reg <= cfg_wdata[3:0];
                tmvs_pkg::REG_BYTE_BUDGET:     byte_budget_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Derive the lane settings from configuration and the held word
    always_comb
    begin
        eff_size = value_size_reg;
        if (eff_size == 4'd0) begin
            eff_size = 4'd1;
        end
        if (eff_size > 4'(tmvs_pkg::MAX_VALUE_BYTES)) begin
            eff_size = 4'(tmvs_pkg::MAX_VALUE_BYTES);
        end
        size_bits = tmvs_pkg::size_mask(eff_size);
        hi_cut    = high_value_reg & size_bits;

        ctl.held_valid = held_valid_reg;
        ctl.contig     = in_req.word_address ==
                         (held_address_reg + 64'(tmvs_pkg::WORD_BYTES));
        ctl.region_end = in_req.region_end;
        ctl.size       = eff_size;
        if (match_alignment_reg >= 4'd8) begin
            ctl.align_mask = 3'd7;
        end else if (match_alignment_reg >= 4'd4) begin
            ctl.align_mask = 3'd3;
        end else if (match_alignment_reg >= 4'd2) begin
            ctl.align_mask = 3'd1;
        end else begin
            ctl.align_mask = 3'd0;
        end
        ctl.vtype    = value_type_reg;
        ctl.lo_cut   = low_value_reg & size_bits;
        ctl.eq_mode  = ctl.lo_cut == hi_cut;
        lo_k         = tmvs_pkg::order_key(ctl.lo_cut, value_type_reg);
        hi_k         = tmvs_pkg::order_key(hi_cut, value_type_reg);
        ctl.range_ok = !lo_k[64] && !hi_k[64];
        ctl.lo_key   = lo_k[63:0];
        ctl.hi_key   = hi_k[63:0];

        s1_item_next.bytes        = {64'd0, in_req.mem_word, held_word_reg};
        s1_item_next.held_address = held_address_reg;
        s1_item_next.word_address = in_req.word_address;
        s1_item_next.fit          = lane_fit;
        s1_item_next.hit          = lane_hit;
    end

    // Test every window start side by side
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tmvs_lane #(
            .LANE (g)
        ) u_lane (
            .ctl   (ctl),
            .bytes (s1_item_next.bytes),
            .fit   (lane_fit[g]),
            .hit   (lane_hit[g])
        );
    end

    assign in_req.ready = !s1_valid_reg || item_done;
    assign in_acc       = in_req.valid && in_req.ready;

    // Advance the word history and the lane result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_word_reg    <= '0;
            held_address_reg <= '0;
            held_valid_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end else begin
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
                s1_item_reg  <= s1_item_next;
                if (in_req.region_end) begin
                    held_valid_reg <= 1'b0;
                end else begin
                    held_word_reg    <= in_req.mem_word;
                    held_address_reg <= in_req.word_address;
                    held_valid_reg   <= 1'b1;
                end
            end else if (item_done) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    tmvs_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (s1_item_reg),
        .item_valid (s1_valid_reg),
        .item_done  (item_done),
        .size       (eff_size),
        .budget     (byte_budget_reg),
        .out_res    (out_res)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the typed memory value scanner core.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [63:0] word;
        bit [63:0] addr;
        bit        last;
    } mem_req_t;

    typedef struct {
        bit        found;
        bit [63:0] addr;
        bit [63:0] value;
        bit [31:0] total;
        bit        limit;
        bit        last;
    } scan_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    tmvs_in_if  in_ch ();
    tmvs_out_if out_ch ();

    typed_memory_value_scanner_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_ch),
        .out_res   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Scanner settings as the block should hold them
    bit [3:0]  cur_type;
    bit [3:0]  cur_size;
    bit [63:0] cur_low;
    bit [63:0] cur_high;
    bit [3:0]  cur_align;
    bit [31:0] cur_budget;

    // Scanner history and counters
    bit [63:0] prev_word;
    bit [63:0] prev_addr;
    bit        prev_valid;
    bit [63:0] stored_bytes;
    bit [31:0] hit_count;
    bit        budget_out;

    mem_req_t  word_queue[$];
    scan_res_t expected_hits[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    function automatic bit [63:0] keep_bytes(bit [63:0] x, int n);
        if (n >= 8) return x;
        return x & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Map an IEEE value of w bits onto an unsigned order; bit 65 marks NaN
    function automatic bit [65:0] ieee_order(bit [63:0] x, int w);
        bit [64:0] half;
        bit [64:0] mag;
        bit        nan;
        half = 65'd1 << (w - 1);
        mag  = {1'b0, x} & (half - 65'd1);
        if (w == 32) begin
            nan = (&x[30:23]) && (|x[22:0]);
        end else begin
            nan = (&x[62:52]) && (|x[51:0]);
        end
        if (x[w-1]) begin
            return {nan, half - mag};
        end
        return {nan, half + mag};
    endfunction

    function automatic bit range_hit(bit [63:0] lo, bit [63:0] hi, bit [63:0] v);
        int        tb_bytes;
        bit [63:0] flip;
        bit [65:0] klo, khi, kv;
        if (cur_type <= tmvs_pkg::TYPE_UINT64) begin
            tb_bytes = 1 << (cur_type >> 1);
            lo = keep_bytes(lo, tb_bytes);
            hi = keep_bytes(hi, tb_bytes);
            v  = keep_bytes(v, tb_bytes);
            if (!cur_type[0]) begin
                flip = 64'd1 << (8 * tb_bytes - 1);
                lo ^= flip;
                hi ^= flip;
                v  ^= flip;
            end
            return v >= lo && v <= hi;
        end
        if (cur_type == tmvs_pkg::TYPE_FLOAT || cur_type == tmvs_pkg::TYPE_DOUBLE) begin
            klo = ieee_order(cur_type == tmvs_pkg::TYPE_FLOAT ? {32'd0, lo[31:0]} : lo,
                             cur_type == tmvs_pkg::TYPE_FLOAT ? 32 : 64);
            khi = ieee_order(cur_type == tmvs_pkg::TYPE_FLOAT ? {32'd0, hi[31:0]} : hi,
                             cur_type == tmvs_pkg::TYPE_FLOAT ? 32 : 64);
            kv  = ieee_order(cur_type == tmvs_pkg::TYPE_FLOAT ? {32'd0, v[31:0]} : v,
                             cur_type == tmvs_pkg::TYPE_FLOAT ? 32 : 64);
            if (klo[65] || khi[65] || kv[65]) return 1'b0;
            return kv[64:0] >= klo[64:0] && kv[64:0] <= khi[64:0];
        end
        return 1'b0;
    endfunction

    // Test every aligned window below start_lim that fits in span bytes
    function automatic void scan_windows(bit [7:0] b[16], int first, int span,
                                         int start_lim, bit [63:0] base);
        int        size;
        int        stride;
        bit [63:0] lo, hi, v;
        bit        hit;
        scan_res_t r;
        size   = (cur_size == 0) ? 1 : (cur_size > 8 ? 8 : cur_size);
        stride = cur_align >= 8 ? 8 : (cur_align >= 4 ? 4 : (cur_align >= 2 ? 2 : 1));
        lo = keep_bytes(cur_low, size);
        hi = keep_bytes(cur_high, size);
        for (int off = 0; off < start_lim; off += stride) begin
            if (budget_out || off + size > span) break;
            r.addr  = base + 64'(off);
            r.last  = 1'b0;
            if (stored_bytes + 64'(size) > {32'd0, cur_budget}) begin
                budget_out = 1'b1;
                r.found = 1'b0;
                r.value = '0;
                r.total = hit_count;
                r.limit = 1'b1;
                expected_hits.insert(expected_hits.size(), r);
                break;
            end
            v = '0;
            for (int i = 0; i < size; i++) v |= 64'(b[first + off + i]) << (8 * i);
            hit = (lo == hi) ? (v == lo) : range_hit(lo, hi, v);
            if (hit) begin
                stored_bytes += 64'(size);
                if (hit_count != 32'hFFFF_FFFF) hit_count++;
                r.found = 1'b1;
                r.value = v;
                r.total = hit_count;
                r.limit = budget_out;
                expected_hits.insert(expected_hits.size(), r);
            end
        end
    endfunction

    // Work out the results of one accepted word
    function automatic void predict_word(bit [63:0] word, bit [63:0] addr, bit last);
        bit [7:0] b[16];
        int       before_n;
        before_n = expected_hits.size();
        for (int i = 0; i < 8; i++) begin
            b[i]     = prev_word[8*i +: 8];
            b[8 + i] = word[8*i +: 8];
        end
        if (prev_valid) begin
            if (addr == prev_addr + 64'd8) begin
                scan_windows(b, 0, 16, last ? 16 : 8, prev_addr);
            end else begin
                scan_windows(b, 0, 8, 8, prev_addr);
                if (last) scan_windows(b, 8, 8, 8, addr);
            end
        end else if (last) begin
            scan_windows(b, 8, 8, 8, addr);
        end
        if (last) begin
            prev_valid = 1'b0;
        end else begin
            prev_word  = word;
            prev_addr  = addr;
            prev_valid = 1'b1;
        end
        if (expected_hits.size() > before_n) expected_hits[$].last = 1'b1;
    endfunction

    // Drive requests from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        mem_req_t q;
        if (!rst_n) begin
            in_ch.valid        <= 1'b0;
            in_ch.mem_word     <= '0;
            in_ch.word_address <= '0;
            in_ch.region_end   <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.mem_word, in_ch.word_address, in_ch.region_end);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    q = word_queue.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.mem_word     <= q.word;
                    in_ch.word_address <= q.addr;
                    in_ch.region_end   <= q.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Check results against the oldest expectation; stall at random
    always @(posedge clk or negedge rst_n)
    begin
        scan_res_t e;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_hits.size() == 0) begin
                    $error("result at %h with no expectation waiting", out_ch.match_address);
                    fail_count++;
                end else begin
                    e = expected_hits.pop_front();
                    check_field("is_match", e.found, out_ch.is_match);
                    check_field("match_address", e.addr, out_ch.match_address);
                    check_field("match_value", e.value, out_ch.match_value);
                    check_field("match_total", e.total, out_ch.match_total);
                    check_field("limit_reached", e.limit, out_ch.limit_reached);
                    check_field("last_of_item", e.last, out_ch.last_of_item);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(tmvs_pkg::reg_index_t idx, bit [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            tmvs_pkg::REG_VALUE_TYPE:      cur_type   = data[3:0];
            tmvs_pkg::REG_VALUE_SIZE:      cur_size   = data[3:0];
            tmvs_pkg::REG_LOW_VALUE:       cur_low    = data;
            tmvs_pkg::REG_HIGH_VALUE:      cur_high   = data;
            tmvs_pkg::REG_MATCH_ALIGNMENT: cur_align  = data[3:0];
            tmvs_pkg::REG_BYTE_BUDGET:     cur_budget = data[31:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Write all settings; junk rides in the unused upper bits
    task automatic setup(bit [3:0] t, bit [3:0] s, bit [63:0] lo, bit [63:0] hi,
                         bit [3:0] a, bit [31:0] budget);
        write_reg(tmvs_pkg::REG_VALUE_TYPE,
                  {$urandom, 16'($urandom_range(65535)), 12'd0, t});
        write_reg(tmvs_pkg::REG_VALUE_SIZE,
                  {$urandom, 16'($urandom_range(65535)), 12'd0, s});
        write_reg(tmvs_pkg::REG_LOW_VALUE, lo);
        write_reg(tmvs_pkg::REG_HIGH_VALUE, hi);
        write_reg(tmvs_pkg::REG_MATCH_ALIGNMENT,
                  {$urandom, 16'($urandom_range(65535)), 12'd0, a});
        write_reg(tmvs_pkg::REG_BYTE_BUDGET, {$urandom, budget});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void push_word(bit [63:0] w, bit [63:0] a, bit last);
        mem_req_t q;
        q.word = w;
        q.addr = a;
        q.last = last;
        word_queue.insert(word_queue.size(), q);
    endfunction

    // Memory content biased toward the bounds so windows match often
    function automatic bit [63:0] make_word();
        bit [63:0] w;
        int        k;
        k = $urandom_range(9);
        if (k == 0) return cur_low;
        if (k == 1) return cur_high;
        if (k == 2) return cur_low << (8 * $urandom_range(7));
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(3))
                0: w[8*i +: 8] = cur_low[8*$urandom_range(7) +: 8];
                1: w[8*i +: 8] = cur_high[8*$urandom_range(7) +: 8];
                2: w[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                default: w[8*i +: 8] = 8'($urandom_range(255));
            endcase
        end
        return w;
    endfunction

    // Queue regions of contiguous words, with stray and broken ones mixed in
    function automatic void fill_random(int n);
        bit [63:0] base;
        int        len;
        while (n > 0) begin
            base = {$urandom, $urandom};
            if ($urandom_range(9) != 0) base[2:0] = 3'd0;
            if ($urandom_range(9) == 0) begin
                push_word({$urandom, $urandom}, base, 1'($urandom_range(1)));
                n--;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len && n > 0; i++) begin
                    push_word(make_word(), base + 64'(8 * i),
                              (i == len - 1) && ($urandom_range(4) != 0));
                    n--;
                end
            end
        end
    endfunction

    // Send the queue and wait until the block has gone quiet
    task automatic run_phase(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        while (word_queue.size() > 0 || in_ch.valid || expected_hits.size() > 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        fail_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_type   = tmvs_pkg::TYPE_INT32;
        cur_size   = 4'd4;
        cur_low    = '0;
        cur_high   = '0;
        cur_align  = 4'd1;
        cur_budget = 32'd1048576;
        prev_word  = '0;
        prev_addr  = '0;
        prev_valid = 1'b0;
        stored_bytes = '0;
        hit_count  = '0;
        budget_out = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, equal match on zero
        push_word(64'd0, 64'h0, 1'b0);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h8, 1'b1);
        push_word(64'h0000_0000_FFFF_0000, 64'h40, 1'b1);
        push_word(64'h0000_0000_0000_0000, 64'h100, 1'b0);
        push_word(64'h1234_0000_0000_5678, 64'h200, 1'b1);
        push_word(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
        push_word(64'h0000_00FF_0000_0000, 64'h0, 1'b1);
        push_word(64'd0, 64'h13, 1'b1);
        push_word(64'h00FF_0000_0000_0000, 64'h300, 1'b0);
        push_word(64'h0000_0000_0000_00FF, 64'h308, 1'b0);
        push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h500, 1'b1);
        run_phase(0);

        // Signed byte range
        setup(tmvs_pkg::TYPE_INT8, 4'd1, 64'h80, 64'h10, 4'd1, 32'hFFFF_FFFF);
        fill_random(8);
        run_phase(1);
        // Unsigned half word range, stride two
        setup(tmvs_pkg::TYPE_UINT16, 4'd2, 64'h0010, 64'hF000, 4'd2, 32'hFFFF_FFFF);
        fill_random(8);
        run_phase(2);
        // Float range with signed zeros, infinity and NaN
        setup(tmvs_pkg::TYPE_FLOAT, 4'd4, 64'hBF80_0000, 64'h4000_0000, 4'd4, 32'd1048576);
        push_word({32'h8000_0000, 32'h0000_0000}, 64'h1000, 1'b0);
        push_word({32'h7FC0_0000, 32'h3F80_0000}, 64'h1008, 1'b0);
        push_word({32'hFF80_0000, 32'h7F80_0000}, 64'h1010, 1'b1);
        fill_random(6);
        run_phase(3);
        // Double range, whole-word stride
        setup(tmvs_pkg::TYPE_DOUBLE, 4'd8, 64'hC000_0000_0000_0000, 64'h4059_0000_0000_0000,
              4'd8, 32'd1048576);
        push_word(64'h8000_0000_0000_0000, 64'h2000, 1'b0);
        push_word(64'h7FF8_0000_0000_0001, 64'h2008, 1'b1);
        fill_random(6);
        run_phase(0);
        // String: equal mode only, then a range that never matches
        setup(tmvs_pkg::TYPE_STRING, 4'd3, 64'h41_4243, 64'h41_4243, 4'd1, 32'd1048576);
        push_word(64'h0041_4243_0041_4243, 64'h3000, 1'b1);
        fill_random(6);
        run_phase(1);
        setup(tmvs_pkg::TYPE_STRING, 4'd3, 64'h0, 64'hFF_FFFF, 4'd1, 32'd1048576);
        fill_random(4);
        run_phase(2);
        // Full unsigned range: every window matches
        setup(tmvs_pkg::TYPE_UINT64, 4'd8, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1,
              32'hFFFF_FFFF);
        fill_random(8);
        run_phase(3);
        // Oversized value size, oversized alignment, signed word range
        setup(tmvs_pkg::TYPE_INT64, 4'd15, 64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0001_0000,
              4'd15, 32'd1048576);
        fill_random(8);
        run_phase(0);
        // Zero value size, alignment three, byte range over every byte
        setup(tmvs_pkg::TYPE_UINT8, 4'd0, 64'h00, 64'hFF, 4'd3, 32'd1048576);
        fill_random(8);
        run_phase(1);
        // Unused type code, alignment seven, equal and range
        setup(4'd15, 4'd2, 64'h00FF, 64'h00FF, 4'd7, 32'd1048576);
        fill_random(6);
        run_phase(2);
        setup(4'd11, 4'd2, 64'h0000, 64'h7FFF, 4'd0, 32'd1048576);
        fill_random(4);
        run_phase(3);
        // Signed and unsigned 32-bit ranges, then a signed 16-bit range
        setup(tmvs_pkg::TYPE_INT32, 4'd4, 64'h8000_0000, 64'h7FFF_FFFF, 4'd1, 32'd1048576);
        fill_random(8);
        run_phase(0);
        setup(tmvs_pkg::TYPE_UINT32, 4'd4, 64'h0000_0100, 64'hFFFF_0000, 4'd2, 32'd1048576);
        fill_random(8);
        run_phase(1);
        setup(tmvs_pkg::TYPE_INT16, 4'd2, 64'hFF00, 64'h00FF, 4'd4, 32'd1048576);
        fill_random(8);
        run_phase(2);
        // Small budget: trip the limit; nothing may follow it
        setup(tmvs_pkg::TYPE_UINT8, 4'd1, 64'h00, 64'hFF, 4'd1,
              32'd0 + (stored_bytes[31:0] + 32'd40));
        fill_random(12);
        run_phase(3);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_hits.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
